// File: design/nearest_palette_color_search_macros.svh
// assertion macros for the nearest palette color search checker
// depends on a clk and rst signal in the scope where the macros are used
`ifndef NEAREST_PALETTE_COLOR_SEARCH_MACROS_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_MACROS_SVH

// same-cycle implication, disabled in reset
`define NPCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define NPCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/npcs_pkg.sv
// shared types and codes for the nearest palette color search
// no dependencies
package npcs_pkg;

  localparam int FIELD_BITS = 8;

  // kind of input word, carried on tuser
  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_WRITE  = 1'b1;

  // palette write request from the control logic
  typedef struct packed {
    logic                  en;
    logic [FIELD_BITS-1:0] idx;
    logic [FIELD_BITS-1:0] red;
    logic [FIELD_BITS-1:0] green;
    logic [FIELD_BITS-1:0] blue;
  } pal_wr_t;

  // palette read request from the scan counter
  typedef struct packed {
    logic                  en;
    logic [FIELD_BITS-1:0] addr;
  } pal_rd_t;

endpackage

// File: design/nearest_palette_color_search.sv
// nearest palette color search, top level
// depends on npcs_pkg and npcs_palette
//
// Keeps a palette of PALETTE_ENTRIES RGB colors (COMPONENT_BITS per
// component) in one synchronous ram. Each input word is either a write
// (tuser = 1), which replaces one entry and gives no output word, or a
// lookup (tuser = 0), which gives one output word holding the index of the
// entry with the least squared euclidean distance to the query color;
// on ties the highest index wins. A write to an index at or above
// PALETTE_ENTRIES is dropped. Components are masked to COMPONENT_BITS.
// After reset the palette holds a grey ramp (entry i = i,i,i) with entry 0
// = 0,0,1, entry PALETTE_ENTRIES-2 yellow and entry PALETTE_ENTRIES-1
// black; no clearing pass is needed, so the block is ready right after
// reset. A lookup reads one entry per cycle from the ram's single read
// port, from the top index down, through a three-stage read / square /
// sum-and-compare pipe, so it occupies the block until its result moves
// into the output register. A new word is taken while an earlier result
// still waits in the output register; a finished lookup waits only if
// that register is still full.
module nearest_palette_color_search #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int COMPONENT_BITS  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // entry_index, red, green, blue
  input  logic [0:0]  s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // color_index
);
  import npcs_pkg::*;

  localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int CB    = COMPONENT_BITS;
  localparam int SQ_W  = 2 * CB;
  localparam int DW    = SQ_W + 2;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_HOLD  = 2'd3;

  logic [1:0]       state, state_next;
  logic             in_acc;
  logic             in_lookup;

  // query color, masked to component width
  logic [CB-1:0]    q_red, q_green, q_blue;

  // scan counter, counts down to zero
  logic [IDX_W-1:0] scan_addr;
  logic             issue;
  logic             issue_last;

  pal_wr_t          pal_wr;
  pal_rd_t          pal_rd;
  logic [3*CB-1:0]  pal_data;

  // pipe stage 1: ram data valid
  logic             p1_vld, p1_last;
  logic [IDX_W-1:0] p1_idx;
  // pipe stage 2: squared differences
  logic             p2_vld, p2_last;
  logic [IDX_W-1:0] p2_idx;
  logic [SQ_W-1:0]  sq_r, sq_g, sq_b;

  logic [DW-1:0]    sum_sq;
  logic [DW-1:0]    best;
  logic [IDX_W-1:0] best_idx;
  logic             first;
  logic             take;
  logic             done;

  logic             out_free;

  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign in_lookup  = in_acc && (s_axis_tuser[0] == ACT_LOOKUP);
  assign issue      = (state == ST_SCAN);
  assign issue_last = issue && (scan_addr == '0);
  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);

  // palette write straight from the input word, read from the scan counter
  always_comb begin
    pal_wr.en    = in_acc && (s_axis_tuser[0] == ACT_WRITE);
    pal_wr.idx   = s_axis_tdata[7:0];
    pal_wr.red   = s_axis_tdata[15:8];
    pal_wr.green = s_axis_tdata[23:16];
    pal_wr.blue  = s_axis_tdata[31:24];
    pal_rd.en    = issue;
    pal_rd.addr  = FIELD_BITS'(scan_addr);
  end

  npcs_palette #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES),
    .COMPONENT_BITS  (COMPONENT_BITS)
  ) u_palette (
    .clk     (clk),
    .rst     (rst),
    .wr      (pal_wr),
    .rd      (pal_rd),
    .rd_data (pal_data)
  );

  // control state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_lookup) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (issue_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (done) state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // query capture and scan counter
  always_ff @(posedge clk) begin
    if (in_lookup) begin
      q_red     <= s_axis_tdata[8 +: CB];
      q_green   <= s_axis_tdata[16 +: CB];
      q_blue    <= s_axis_tdata[24 +: CB];
      scan_addr <= IDX_W'(PALETTE_ENTRIES - 1);
    end else if (issue && !issue_last) begin
      scan_addr <= scan_addr - 1'b1;
    end
  end

  // pipe valids
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
    end else begin
      p1_vld <= issue;
      p2_vld <= p1_vld;
    end
  end

  function automatic logic [SQ_W-1:0] sq_diff(input logic [CB-1:0] a,
                                               input logic [CB-1:0] b);
    logic [CB-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    sq_diff = SQ_W'(d) * SQ_W'(d);
  endfunction

  // stage payloads
  always_ff @(posedge clk) begin
    p1_last <= issue_last;
    p1_idx  <= scan_addr;
    p2_last <= p1_last;
    p2_idx  <= p1_idx;
    sq_r    <= sq_diff(pal_data[0 +: CB], q_red);
    sq_g    <= sq_diff(pal_data[CB +: CB], q_green);
    sq_b    <= sq_diff(pal_data[2*CB +: CB], q_blue);
  end

  // sum and strict less-than compare; first entry is always taken
  assign sum_sq = DW'(sq_r) + DW'(sq_g) + DW'(sq_b);
  assign take   = p2_vld && (first || (sum_sq < best));
  assign done   = p2_vld && p2_last;

  always_ff @(posedge clk) begin
    if (take) begin
      best     <= sum_sq;
      best_idx <= p2_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first <= 1'b0;
    end else if (in_lookup) begin
      first <= 1'b1;
    end else if (p2_vld) begin
      first <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_HOLD && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_HOLD && out_free) begin
      m_axis_tdata <= 8'(best_idx);
    end
  end

endmodule

// File: design/npcs_palette.sv
// palette storage: one synchronous ram, per-entry valid bits, reset table
// depends on npcs_pkg
module npcs_palette #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int COMPONENT_BITS  = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  npcs_pkg::pal_wr_t             wr,
  input  npcs_pkg::pal_rd_t             rd,
  output logic [3*COMPONENT_BITS-1:0]   rd_data  // red, green, blue from low bits
);
  import npcs_pkg::*;

  localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int CB    = COMPONENT_BITS;
  localparam int EW    = 3 * CB;

  logic [EW-1:0]              mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] written;
  logic [EW-1:0]              rd_q;
  logic                       rd_written;
  logic [IDX_W-1:0]           rd_idx;
  logic [IDX_W-1:0]           wr_addr;
  logic [IDX_W-1:0]           rd_addr;
  logic                       wr_in_range;

  // contents of an entry that has not been written since reset
  function automatic logic [EW-1:0] reset_entry(input logic [IDX_W-1:0] i);
    logic [FIELD_BITS-1:0] i8;
    logic [CB-1:0]         g;
    logic [CB-1:0]         full;
    logic [CB-1:0]         one;
    i8   = FIELD_BITS'(i);
    g    = i8[CB-1:0];
    full = '1;
    one  = CB'(1);
    if (i == IDX_W'(PALETTE_ENTRIES - 1)) begin
      reset_entry = '0;
    end else if (i == IDX_W'(PALETTE_ENTRIES - 2)) begin
      reset_entry = {CB'(0), full, full};
    end else if (i == '0) begin
      reset_entry = {one, CB'(0), CB'(0)};
    end else begin
      reset_entry = {g, g, g};
    end
  endfunction

  assign wr_addr     = wr.idx[IDX_W-1:0];
  assign rd_addr     = rd.addr[IDX_W-1:0];
  assign wr_in_range = ({1'b0, wr.idx} < 9'(PALETTE_ENTRIES));

  always_ff @(posedge clk) begin
    if (wr.en && wr_in_range) begin
      mem[wr_addr] <= {wr.blue[CB-1:0], wr.green[CB-1:0], wr.red[CB-1:0]};
    end
    if (rd.en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr.en && wr_in_range) begin
      written[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_written <= written[rd_addr];
      rd_idx     <= rd_addr;
    end
  end

  assign rd_data = rd_written ? rd_q : reset_entry(rd_idx);

endmodule

// File: design/npcs_checker.sv
// port-level checks for the nearest palette color search
// depends on npcs_pkg and nearest_palette_color_search_macros.svh
`include "nearest_palette_color_search_macros.svh"

module npcs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic [0:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);
  import npcs_pkg::*;

  logic       in_acc;
  logic       lookup_acc;
  logic       write_acc;
  logic       out_acc;
  logic [1:0] owed;

  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign lookup_acc = in_acc && (s_axis_tuser[0] == ACT_LOOKUP);
  assign write_acc  = in_acc && (s_axis_tuser[0] == ACT_WRITE);
  assign out_acc    = m_axis_tvalid && m_axis_tready;

  // lookups taken whose word has not left yet
  always_ff @(posedge clk) begin
    if (rst) begin
      owed <= '0;
    end else begin
      owed <= owed + 2'(lookup_acc) - 2'(out_acc);
    end
  end

  `NPCS_ASSERT_NOW(a_no_spurious_out, m_axis_tvalid, owed != 2'd0, "output word without a lookup")
  `NPCS_ASSERT_NOW(a_two_owed_stalls, owed == 2'd2, !s_axis_tready, "third lookup taken")
  `NPCS_ASSERT_NEXT(a_write_silent, write_acc && owed == 2'd0 && !m_axis_tvalid, !m_axis_tvalid, "write gave an output word")
  `NPCS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled output word changed")

endmodule

bind nearest_palette_color_search npcs_checker u_npcs_checker (.*);
